// ===== rtl/kpd_pkg.sv =====
// Shared types, constants and key code table for the keypad scanner.
package kpd_pkg;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 4;
  localparam int CODE_W = 8;
  localparam int NUM_W  = 32;
  localparam int TICK_W = 16;

  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd20;

  // register indexes
  localparam logic REG_DEBOUNCE = 1'b0;

  // character codes
  localparam logic [CODE_W-1:0] KEY_RESET  = 8'h52; // R
  localparam logic [CODE_W-1:0] KEY_MUL    = 8'h2A;
  localparam logic [CODE_W-1:0] KEY_DIV    = 8'h2F;
  localparam logic [CODE_W-1:0] KEY_SUB    = 8'h2D;
  localparam logic [CODE_W-1:0] KEY_MOD    = 8'h25;
  localparam logic [CODE_W-1:0] KEY_ADD    = 8'h2B;
  localparam logic [CODE_W-1:0] KEY_POW    = 8'h5E;
  localparam logic [CODE_W-1:0] KEY_DOT    = 8'h2E;
  localparam logic [CODE_W-1:0] KEY_EQUALS = 8'h3D;

  typedef struct packed {
    logic [ROW_W-1:0]        row_drive;
    logic                    key_valid;
    logic [CODE_W-1:0]       key_code;
    logic                    number_valid;
    logic signed [NUM_W-1:0] number;
  } result_t;

  function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] row,
                                                   input logic [2:0] col);
    logic [CODE_W-1:0] code;
    code = '0;
    unique case (row)
      2'd0: begin
        unique case (col)
          3'd0: code = KEY_RESET;
          3'd1: code = 8'd7;
          3'd2: code = 8'd8;
          3'd3: code = 8'd9;
          3'd4: code = KEY_MUL;
          3'd5: code = KEY_DIV;
          default: code = '0;
        endcase
      end
      2'd1: begin
        unique case (col)
          3'd1: code = 8'd4;
          3'd2: code = 8'd5;
          3'd3: code = 8'd6;
          3'd4: code = KEY_SUB;
          default: code = '0;
        endcase
      end
      2'd2: begin
        unique case (col)
          3'd0: code = KEY_MOD;
          3'd1: code = 8'd1;
          3'd2: code = 8'd2;
          3'd3: code = 8'd3;
          3'd4: code = KEY_ADD;
          default: code = '0;
        endcase
      end
      2'd3: begin
        unique case (col)
          3'd0: code = KEY_POW;
          3'd2: code = KEY_DOT;
          3'd3: code = KEY_EQUALS;
          3'd4: code = KEY_ADD;
          default: code = '0;
        endcase
      end
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/kpd_apb_regs.sv =====
// APB register file holding the debounce length.
module kpd_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [kpd_pkg::TICK_W-1:0] debounce_ticks
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == kpd_pkg::REG_DEBOUNCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= kpd_pkg::DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && hit) begin
      debounce_ticks <= pwdata[kpd_pkg::TICK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(32 - kpd_pkg::TICK_W){1'b0}}, debounce_ticks};
    end
  end

endmodule

// ===== rtl/kpd_scan_ctrl.sv =====
// Scan and debounce sequencer with decimal accumulator.
module kpd_scan_ctrl #(
  parameter int KEY_ROWS = 4,
  parameter int KEY_COLS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [kpd_pkg::COL_W-1:0]   cols,
  input  logic [kpd_pkg::TICK_W-1:0]  debounce_ticks,
  output kpd_pkg::result_t            result
);

  localparam logic [1:0] PH_RELEASE = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_SETTLE  = 2'd2;
  localparam logic [1:0] PH_SCAN    = 2'd3;

  localparam logic [kpd_pkg::COL_W-1:0] COL_MASK =
    kpd_pkg::COL_W'((1 << KEY_COLS) - 1);

  logic [1:0]                 phase, phase_next;
  logic [1:0]                 scan_row, scan_row_next;
  logic [kpd_pkg::TICK_W-1:0] settle_count, settle_count_next, settle_inc;
  logic [kpd_pkg::NUM_W-1:0]  accumulator, accumulator_next;
  logic                       released;
  logic                       found;
  logic [2:0]                 hit_col;
  logic [2:0]                 row_plus;
  logic [1:0]                 next_row;
  logic [kpd_pkg::CODE_W-1:0] code;

  assign released = ((cols & COL_MASK) == COL_MASK);
  assign settle_inc = settle_count + kpd_pkg::TICK_W'(1);
  assign row_plus = {1'b0, scan_row} + 3'd1;
  assign next_row = row_plus[1:0];

  // lowest low column wins
  always_comb begin
    found   = 1'b0;
    hit_col = '0;
    for (int c = kpd_pkg::COL_W - 1; c >= 0; c--) begin
      if (c < KEY_COLS && !cols[c]) begin
        found   = 1'b1;
        hit_col = 3'(c);
      end
    end
  end

  assign code = kpd_pkg::key_lookup(scan_row, hit_col);

  always_comb begin
    phase_next        = phase;
    scan_row_next     = scan_row;
    settle_count_next = settle_count;
    accumulator_next  = accumulator;
    result            = '0;
    unique case (phase)
      PH_RELEASE: begin
        if (released) phase_next = PH_PRESS;
      end
      PH_PRESS: begin
        if (!released) begin
          phase_next        = PH_SETTLE;
          settle_count_next = '0;
        end
      end
      PH_SETTLE: begin
        settle_count_next = settle_inc;
        if (settle_inc >= debounce_ticks || settle_inc == '0) begin
          settle_count_next = '0;
          if (!released) begin
            phase_next       = PH_SCAN;
            scan_row_next    = '0;
            result.row_drive = 4'b1110;
          end else begin
            phase_next = PH_PRESS;
          end
        end
      end
      PH_SCAN: begin
        if (found) begin
          result.key_valid = 1'b1;
          result.key_code  = code;
          if (code == kpd_pkg::KEY_EQUALS) begin
            result.number_valid = 1'b1;
            result.number       = accumulator;
            accumulator_next    = '0;
          end else begin
            accumulator_next = (accumulator << 3) + (accumulator << 1)
                             + {{(kpd_pkg::NUM_W - kpd_pkg::CODE_W){1'b0}}, code};
          end
          phase_next    = PH_RELEASE;
          scan_row_next = '0;
        end else if (row_plus < 3'(KEY_ROWS)) begin
          scan_row_next    = next_row;
          result.row_drive = ~(4'b0001 << next_row);
        end else begin
          phase_next    = PH_RELEASE;
          scan_row_next = '0;
        end
      end
      default: phase_next = PH_RELEASE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RELEASE;
      scan_row     <= '0;
      settle_count <= '0;
      accumulator  <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      scan_row     <= scan_row_next;
      settle_count <= settle_count_next;
      accumulator  <= accumulator_next;
    end
  end

  // scan row stays zero outside of scan
  a_row_idle: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_SCAN) |-> (scan_row == 2'd0))
    else $error("scan_row nonzero outside scan");

  // accumulator clears after a number is reported
  a_num_eq: assert property (@(posedge clk) disable iff (rst)
    (advance && result.number_valid) |=> (accumulator == '0))
    else $error("accumulator not cleared after number");

  // settle counter only moves while settling
  a_settle: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_SETTLE) |-> (settle_count == '0))
    else $error("settle_count nonzero outside settle");

endmodule

// ===== rtl/matrix_keypad_scan_debounce.sv =====
// An accepted word waits in the input register, then its result is registered.
// One word per cycle while not stalled; the sequencer advances once per word.
// Input register and result register decouple the two channels.
// Reset: synchronous; scan state, accumulator and valids clear,
// debounce_ticks returns to 20.
module matrix_keypad_scan_debounce #(
  parameter int KEY_ROWS = 4,
  parameter int KEY_COLS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [5:0]  column_lines,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  row_drive,
  output logic        key_valid,
  output logic [7:0]  key_code,
  output logic        number_valid,
  output logic signed [31:0] number
);

  logic [kpd_pkg::TICK_W-1:0] debounce_ticks;
  logic                       s1_valid;
  logic [kpd_pkg::COL_W-1:0]  s1_cols;
  logic                       advance;
  logic                       accept;
  kpd_pkg::result_t           step_result;
  kpd_pkg::result_t           out_word;

  kpd_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .debounce_ticks (debounce_ticks)
  );

  kpd_scan_ctrl #(
    .KEY_ROWS (KEY_ROWS),
    .KEY_COLS (KEY_COLS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .cols           (s1_cols),
    .debounce_ticks (debounce_ticks),
    .result         (step_result)
  );

  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_cols <= column_lines;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word <= step_result;
  end

  assign row_drive    = out_word.row_drive;
  assign key_valid    = out_word.key_valid;
  assign key_code     = out_word.key_code;
  assign number_valid = out_word.number_valid;
  assign number       = out_word.number;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (s1_valid && result_valid))
    else $error("input stalled with room in pipeline");

  a_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost");

  a_key_rows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && key_valid) |-> (row_drive == 4'd0))
    else $error("rows not all low on key report");

  a_num_key: assert property (@(posedge clk) disable iff (rst)
    (result_valid && number_valid) |-> (key_valid && key_code == kpd_pkg::KEY_EQUALS))
    else $error("number without equals key");

endmodule
